FILE: hdl/ppid_pkg.sv
package ppid_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int ERR_W       = 17;
   localparam int DELTA_W     = 18;
   localparam int SUM_W       = 32;
   localparam int LIMIT_W     = 17;
   localparam int GAIN_W      = 16;
   localparam int DRIVE_W     = 32;
   localparam int PROD_P_W    = GAIN_W + ERR_W;
   localparam int PROD_I_W    = GAIN_W + SUM_W;
   localparam int PROD_D_W    = GAIN_W + DELTA_W;
   localparam int ACC_W       = PROD_I_W + 2;
   localparam int FRAC_W      = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 17;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] REG_TARGET     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SEP_LIMIT  = 3'd4;

   // classified sample handed from front to back
   typedef struct packed {
      logic signed [ERR_W-1:0]   err;
      logic signed [DELTA_W-1:0] delta;
      logic signed [SUM_W-1:0]   esum;
      logic                      integ;
   } ppid_item_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop;
      logic signed [GAIN_W-1:0] integ;
      logic signed [GAIN_W-1:0] deriv;
   } ppid_gains_type;

endpackage

FILE: hdl/ppid_front.sv
module ppid_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   input  logic signed [ppid_pkg::SAMPLE_W-1:0]   req_feedback,
   input  logic signed [ppid_pkg::SAMPLE_W-1:0]   target,
   input  logic        [ppid_pkg::LIMIT_W-1:0]    sep_limit,
   input  logic                                   queue_full,
   output logic                                   req_full,
   output logic                                   item_push,
   output ppid_pkg::ppid_item_type                item
);
   import ppid_pkg::*;

   logic signed [ERR_W-1:0] last_error_ff, last_error_in;
   logic signed [SUM_W-1:0] error_sum_ff, error_sum_in;
   logic signed [ERR_W-1:0] err;
   logic        [ERR_W-1:0] mag;
   logic                    in_band;
   logic signed [SUM_W:0]   sum_wide;
   logic signed [SUM_W-1:0] sum_sat;

   assign req_full  = queue_full;
   assign item_push = req_push && !queue_full;

   always_comb begin
      err = {{(ERR_W-SAMPLE_W){target[SAMPLE_W-1]}}, target}
          - {{(ERR_W-SAMPLE_W){req_feedback[SAMPLE_W-1]}}, req_feedback};
      mag     = err[ERR_W-1] ? -err : err;
      in_band = mag <= sep_limit;

      sum_wide = {error_sum_ff[SUM_W-1], error_sum_ff}
               + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         // overflow: clamp toward the sign of the true sum
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end

      error_sum_in  = in_band ? sum_sat : '0;
      last_error_in = err;

      item.err   = err;
      item.delta = {err[ERR_W-1], err} - {last_error_ff[ERR_W-1], last_error_ff};
      item.esum  = error_sum_in;
      item.integ = in_band;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         error_sum_ff  <= '0;
      end else if (item_push) begin
         last_error_ff <= last_error_in;
         error_sum_ff  <= error_sum_in;
      end
   end

   a_sep_clears: assert property (@(posedge clock) disable iff (reset)
      item_push && !item.integ |=> error_sum_ff == '0)
      else $error("integral not cleared outside the separation limit");

endmodule

FILE: hdl/ppid_fifo.sv
module ppid_fifo #(
   parameter int DEPTH = ppid_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ppid_pkg::ppid_item_type item_in,
   output logic                    full,
   input  logic                    pop,
   output ppid_pkg::ppid_item_type item_out,
   output logic                    empty
);
   import ppid_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ppid_item_type     slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = count_ff == FULL_CNT;
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign item_out = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

endmodule

FILE: hdl/ppid_back.sv
module ppid_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 item_valid,
   input  ppid_pkg::ppid_item_type              item,
   input  ppid_pkg::ppid_gains_type             gains,
   output logic                                 item_pop,
   input  logic                                 rsp_pop,
   output logic                                 rsp_empty,
   output logic signed [ppid_pkg::DRIVE_W-1:0]  rsp_drive,
   output logic                                 rsp_integrating
);
   import ppid_pkg::*;

   localparam int Q_W = ACC_W - FRAC_W;

   logic                       adv;
   logic                       s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic signed [PROD_P_W-1:0] s1_p_ff, s1_p_in;
   logic signed [PROD_I_W-1:0] s1_i_ff, s1_i_in;
   logic signed [PROD_D_W-1:0] s1_d_ff, s1_d_in;
   logic                       s1_integ_ff;
   logic signed [ACC_W-1:0]    s2_acc_ff, s2_acc_in;
   logic                       s2_integ_ff;
   logic signed [ACC_W-1:0]    rnd;
   logic signed [Q_W-1:0]      quo;
   logic signed [DRIVE_W-1:0]  drive_in, out_drive_ff;
   logic                       out_integ_ff;

   // whole pipe moves together; holds while the result waits
   assign adv       = !out_valid_ff || rsp_pop;
   assign item_pop  = adv && item_valid;
   assign rsp_empty = !out_valid_ff;
   assign rsp_drive = out_drive_ff;
   assign rsp_integrating = out_integ_ff;

   always_comb begin
      s1_p_in = $signed(gains.prop)  * $signed(item.err);
      s1_i_in = $signed(gains.integ) * $signed(item.esum);
      s1_d_in = $signed(gains.deriv) * $signed(item.delta);

      s2_acc_in = {{(ACC_W-PROD_P_W){s1_p_ff[PROD_P_W-1]}}, s1_p_ff}
                + {{(ACC_W-PROD_I_W){s1_i_ff[PROD_I_W-1]}}, s1_i_ff}
                + {{(ACC_W-PROD_D_W){s1_d_ff[PROD_D_W-1]}}, s1_d_ff};

      // bias negatives so the arithmetic shift truncates toward zero
      rnd = s2_acc_ff + (s2_acc_ff[ACC_W-1] ? ACC_W'((1 << FRAC_W) - 1) : '0);
      quo = rnd[ACC_W-1:FRAC_W];
      if (quo[Q_W-1:DRIVE_W-1] == '0 || quo[Q_W-1:DRIVE_W-1] == '1) begin
         drive_in = quo[DRIVE_W-1:0];
      end else if (quo[Q_W-1]) begin
         drive_in = {1'b1, {(DRIVE_W-1){1'b0}}};
      end else begin
         drive_in = {1'b0, {(DRIVE_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= item_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_p_ff      <= s1_p_in;
         s1_i_ff      <= s1_i_in;
         s1_d_ff      <= s1_d_in;
         s1_integ_ff  <= item.integ;
         s2_acc_ff    <= s2_acc_in;
         s2_integ_ff  <= s1_integ_ff;
         out_drive_ff <= drive_in;
         out_integ_ff <= s2_integ_ff;
      end
   end

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_pop |=> out_valid_ff && $stable(s2_valid_ff)
         && $stable(s1_valid_ff))
      else $error("pipeline moved while the result was stalled");

endmodule

FILE: hdl/positional_pid_integral_separation.sv
// Positional PID controller with integral separation.
//
// Input channel: drive req_feedback and raise req_push; the sample is taken
// at a clock edge where req_full is low. Samples may arrive every cycle.
// Result channel: while rsp_empty is low, rsp_drive and rsp_integrating hold
// the oldest result; raising rsp_pop takes it at the next edge.
// Control registers are written through csr_valid/csr_index/csr_data
// (csr_ready is always high); write them only while no sample is in flight.
//
// A sample taken from the input is written to the queue, then moves
// through the registered back stages (queue read and the three gain
// multiplies, then the sum, then shift and clamp) to the result ports.
// Throughput: one sample per cycle while req_full is low, set by the
// error/integral update in the front end. When the receiver stalls, the
// back pipeline holds and the front keeps accepting until the
// QUEUE_DEPTH-entry queue fills, which raises req_full.
// Reset (synchronous): gains, target, limit, integral and previous error go
// to zero and both the queue and pipeline are emptied.
module positional_pid_integral_separation #(
   parameter int QUEUE_DEPTH = ppid_pkg::QUEUE_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic signed [ppid_pkg::SAMPLE_W-1:0]   req_feedback,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic signed [ppid_pkg::DRIVE_W-1:0]    rsp_drive,
   output logic                                   rsp_integrating,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic        [ppid_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [ppid_pkg::CSR_DATA_W-1:0] csr_data
);
   import ppid_pkg::*;

   logic signed [SAMPLE_W-1:0] target_ff;
   logic        [LIMIT_W-1:0]  sep_limit_ff;
   ppid_gains_type             gains_ff;

   ppid_item_type front_item, queue_item;
   logic          queue_full, queue_empty, front_push, back_pop;

   // control registers; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         sep_limit_ff <= '0;
         gains_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TARGET:     target_ff      <= csr_data[SAMPLE_W-1:0];
            REG_PROP_GAIN:  gains_ff.prop  <= csr_data[GAIN_W-1:0];
            REG_INTEG_GAIN: gains_ff.integ <= csr_data[GAIN_W-1:0];
            REG_DERIV_GAIN: gains_ff.deriv <= csr_data[GAIN_W-1:0];
            REG_SEP_LIMIT:  sep_limit_ff   <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // front: error, separation test, integral and error delta
   ppid_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_feedback (req_feedback),
      .target       (target_ff),
      .sep_limit    (sep_limit_ff),
      .queue_full   (queue_full),
      .req_full     (req_full),
      .item_push    (front_push),
      .item         (front_item)
   );

   // decouples the stateful front from the stallable multiply pipe
   ppid_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .item_in  (front_item),
      .full     (queue_full),
      .pop      (back_pop),
      .item_out (queue_item),
      .empty    (queue_empty)
   );

   // back: gain products, sum, truncate toward zero, clamp
   ppid_back u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (!queue_empty),
      .item            (queue_item),
      .gains           (gains_ff),
      .item_pop        (back_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_drive       (rsp_drive),
      .rsp_integrating (rsp_integrating)
   );

endmodule

FILE: sim/positional_pid_integral_separation_test.sv
module positional_pid_integral_separation_test;
   import ppid_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // index codes the block has no register for; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   // at full-scale error the integral term passes the drive clamp after
   // about 257 samples
   localparam int SAT_ITEMS     = 300;
   localparam int RANDOM_ITEMS  = 1250;
   localparam int SETTLE_CYCLES = 8;      // leave margin for the pipeline to go quiet
   localparam int HOLD_CYCLES   = 240;    // long receiver hold-off
   localparam int CYCLE_LIMIT   = 1500000;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef sample_type sample_set_type [5];

   typedef struct {
      logic signed [DRIVE_W-1:0] drive;
      logic                      integrating;
   } drive_item_type;

   typedef enum int {FEED_FIXED, FEED_MIXED} feed_mode_type;

   // Tracks controller state and the drive values still owed by the block.
   class drive_scoreboard_type;
      logic signed [GAIN_W-1:0] target     = '0;
      logic signed [GAIN_W-1:0] prop_gain  = '0;
      logic signed [GAIN_W-1:0] integ_gain = '0;
      logic signed [GAIN_W-1:0] deriv_gain = '0;
      logic        [LIMIT_W-1:0] sep_limit = '0;
      logic signed [ERR_W-1:0]  last_error = '0;
      logic signed [SUM_W-1:0]  error_sum  = '0;
      drive_item_type expected_drives[$];
      int unsigned errors, checked, integrated, cleared;
      int unsigned sum_clamps, drive_hi, drive_lo;

      function longint clamp32(longint v);
         if (v > SAT_HI) return SAT_HI;
         if (v < SAT_LO) return SAT_LO;
         return v;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_TARGET:     target     = data[GAIN_W-1:0];
            REG_PROP_GAIN:  prop_gain  = data[GAIN_W-1:0];
            REG_INTEG_GAIN: integ_gain = data[GAIN_W-1:0];
            REG_DERIV_GAIN: deriv_gain = data[GAIN_W-1:0];
            REG_SEP_LIMIT:  sep_limit  = data[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] feedback);
         longint err, sum, acc, q;
         bit in_band;
         drive_item_type item;
         err = longint'(target) - longint'(feedback);
         in_band = ((err < 0) ? -err : err) <= longint'(sep_limit);
         if (in_band) begin
            sum = clamp32(longint'(error_sum) + err);
            if (sum != longint'(error_sum) + err) sum_clamps++;
            integrated++;
         end else begin
            sum = 0;
            cleared++;
         end
         error_sum = sum[SUM_W-1:0];
         acc = longint'(prop_gain) * err + longint'(integ_gain) * sum
             + longint'(deriv_gain) * (err - longint'(last_error));
         q = acc / (longint'(1) << FRAC_W);   // truncates toward zero
         if (q > SAT_HI) drive_hi++;
         if (q < SAT_LO) drive_lo++;
         q = clamp32(q);
         last_error = err[ERR_W-1:0];
         item.drive = q[DRIVE_W-1:0];
         item.integrating = in_band;
         expected_drives.push_back(item);
      endfunction

      function void check_drive(logic signed [DRIVE_W-1:0] drive, logic integrating);
         drive_item_type want;
         if (expected_drives.size() == 0) begin
            errors++;
            $display("%0t: unexpected item: expected none, got drive %0d integrating %0b",
                     $time, drive, integrating);
            return;
         end
         want = expected_drives.pop_front();
         checked++;
         if (drive !== want.drive) begin
            errors++;
            $display("%0t: drive expected %0d, got %0d", $time, want.drive, drive);
         end
         if (integrating !== want.integrating) begin
            errors++;
            $display("%0t: integrating expected %0b, got %0b",
                     $time, want.integrating, integrating);
         end
      endfunction

      function int pending();
         return expected_drives.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // clock, reset, block inputs (all known from time zero)
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_push     = 1'b0;
   logic                  req_full;
   sample_type            req_feedback = '0;
   logic                  rsp_empty;
   logic                  rsp_pop      = 1'b0;
   logic signed [DRIVE_W-1:0] rsp_drive;
   logic                  rsp_integrating;
   logic                  csr_valid    = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_data     = '0;

   always #1 clock = ~clock;

   positional_pid_integral_separation dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_feedback    (req_feedback),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_drive       (rsp_drive),
      .rsp_integrating (rsp_integrating),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   drive_scoreboard_type sb = new();

   // driver-side copy of the setpoint and limit, used to aim samples
   sample_type         cur_target = '0;
   logic [LIMIT_W-1:0] cur_limit  = '0;

   bit          hold_off_req = 1'b0;   // driver asks receiver for a long hold-off
   int unsigned samples_sent, config_phases, full_cycles, cycle_count;

   // ---------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge, before the NBA
   // updates of that edge land, so handshakes are seen exactly as the
   // block sees them.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (rsp_pop && !rsp_empty) sb.check_drive(rsp_drive, rsp_integrating);
         if (req_push && !req_full) sb.note_sample(req_feedback);
         if (req_push && req_full) full_cycles++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d items outstanding",
                  cycle_count, sb.pending());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: pop rate changes in random segments (from always-pop down
   // to mostly stalled); on request it holds off for HOLD_CYCLES so the
   // queue fills and req_full rises.
   // ---------------------------------------------------------------------
   initial begin : receiver
      int pct;
      int seg;
      pct = 100;
      seg = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (seg == 0) begin
               case ($urandom_range(0, 4))
                  0, 1: pct = 100;
                  2:    pct = 75;
                  3:    pct = 40;
                  default: pct = 20;
               endcase
               seg = $urandom_range(16, 160);
            end
            seg--;
            rsp_pop <= ($urandom_range(1, 100) <= pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // csr_valid stays high across back-to-back writes; caller lowers it
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // writes every register; spare top bit of 16-bit registers is random
   task automatic set_config(input sample_type t, input sample_type kp,
                             input sample_type ki, input sample_type kd,
                             input logic [LIMIT_W-1:0] lim);
      write_reg(REG_TARGET,     {1'($urandom_range(0, 1)), t});
      write_reg(REG_PROP_GAIN,  {1'($urandom_range(0, 1)), kp});
      write_reg(REG_INTEG_GAIN, {1'($urandom_range(0, 1)), ki});
      write_reg(REG_DERIV_GAIN, {1'($urandom_range(0, 1)), kd});
      write_reg(REG_SEP_LIMIT,  lim);
      if ($urandom_range(0, 2) == 0)
         write_reg(3'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
                   CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      cur_target = t;
      cur_limit  = lim;
      config_phases++;
   endtask

   // wait for all owed drive values, then let the pipeline go quiet
   task automatic settle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // push stays high for the next item; a gap or the caller lowers it
   task automatic send_sample(input sample_type fb);
      req_push     <= 1'b1;
      req_feedback <= fb;
      @(posedge clock);
      while (req_full) @(posedge clock);
      samples_sent++;
   endtask

   task automatic send_set(input sample_set_type vals);
      foreach (vals[i]) send_sample(vals[i]);
      req_push <= 1'b0;
   endtask

   function automatic sample_type pick_word();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         3: return 16'sh0100;                              // 1.0 in Q8.8
         4: return sample_type'(int'($urandom_range(0, 1023)) - 512);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic logic [LIMIT_W-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 17'd65535;
         3, 4: return LIMIT_W'($urandom_range(0, 300));
         default: return LIMIT_W'($urandom);
      endcase
   endfunction

   // mostly errors inside the separation band, some right at its edge,
   // the rest extremes and noise
   function automatic sample_type mixed_feedback();
      longint span, e, fb;
      span = (cur_limit > 40000) ? 40000 : longint'(cur_limit);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: e = longint'($urandom_range(0, 2 * span)) - span;
         4, 5: e = ($urandom_range(0, 1) ? longint'(cur_limit) : -longint'(cur_limit))
                   + longint'($urandom_range(0, 2)) - 1;
         6: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return sample_type'($urandom);
      endcase
      fb = longint'(cur_target) - e;
      if (fb > 32767) fb = 32767;
      if (fb < -32768) fb = -32768;
      return fb[SAMPLE_W-1:0];
   endfunction

   // bursts of random length separated by random idle gaps
   task automatic stream_samples(input int count, input feed_mode_type mode,
                                 input sample_type fixed_value, input int max_gap);
      int burst;
      int gap;
      burst = $urandom_range(1, 48);
      for (int i = 0; i < count; i++) begin
         send_sample(mode == FEED_FIXED ? fixed_value : mixed_feedback());
         burst--;
         if (burst == 0) begin
            gap = $urandom_range(0, max_gap);
            if (gap > 0) begin
               req_push     <= 1'b0;
               req_feedback <= sample_type'($urandom);
               repeat (gap) @(posedge clock);
            end
            burst = $urandom_range(1, 48);
         end
      end
      req_push <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int random_items;
      int n;
      int max_gap;
      int phase;
      random_items = 0;
      phase = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: zero gains, zero target, zero limit (only fb == 0 integrates)
      send_set('{16'sh0000, 16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff});

      // tiny gain: negative products must truncate toward zero (-1/256 -> 0,
      // -255/256 -> 0, -257/256 -> -1); unmapped index writes must not land
      settle();
      write_reg(REG_UNMAPPED_LO, '1);
      write_reg(REG_UNMAPPED_HI, '1);
      set_config(16'sh0000, 16'sh0001, 16'sh0000, 16'sh0000, '0);
      send_set('{16'sh0001, 16'shffff, 16'sh00ff, 16'sh0101, 16'sh0000});

      // error exactly at the limit integrates, one past it clears
      settle();
      set_config(16'sd100, 16'sh0100, 16'sh0100, 16'sh0100, 17'd50);
      send_set('{16'sd50, 16'sd150, 16'sd49, 16'sd151, 16'sd100});

      // full-scale target and gains, largest error swings
      settle();
      set_config(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, '1);
      send_set('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh0000});

      // random configurations; one phase runs against a stalled receiver
      while (random_items < RANDOM_ITEMS) begin
         settle();
         set_config(pick_word(), pick_word(), pick_word(), pick_word(), pick_limit());
         n = $urandom_range(60, 220);
         case ($urandom_range(0, 2))
            0: max_gap = 0;
            1: max_gap = 4;
            default: max_gap = 15;
         endcase
         if (phase == 3) begin
            hold_off_req = 1'b1;
            max_gap = 0;
         end
         stream_samples(n, FEED_MIXED, '0, max_gap);
         random_items += n;
         phase++;
      end

      // integral grows at full-scale error until the drive clamps high
      settle();
      set_config(16'sh7fff, 16'sh0000, 16'sh7fff, 16'sh0000, '1);
      stream_samples(SAT_ITEMS, FEED_FIXED, 16'sh8000, 3);

      // clear the integral with a zero limit, then drive the clamp low
      settle();
      set_config(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, '0);
      send_sample(16'sh0000);
      req_push <= 1'b0;
      settle();
      write_reg(REG_SEP_LIMIT, '1);
      csr_valid <= 1'b0;
      cur_limit = '1;
      stream_samples(SAT_ITEMS, FEED_FIXED, 16'sh7fff, 3);

      settle();

      $display("Run covered %0d samples over %0d register settings: %0d integrated, %0d cleared",
               samples_sent, config_phases, sb.integrated, sb.cleared);
      $display("Integral clamps %0d, drive clamps high %0d low %0d, input full for %0d cycles",
               sb.sum_clamps, sb.drive_hi, sb.drive_lo, full_cycles);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: files.f
hdl/ppid_pkg.sv
hdl/ppid_front.sv
hdl/ppid_fifo.sv
hdl/ppid_back.sv
hdl/positional_pid_integral_separation.sv
sim/positional_pid_integral_separation_test.sv
